FILE: hw/rtl/cp0_access_emulator_defines.svh
// Assertion macros shared by the CP0 access emulator RTL.
`ifndef CP0_ACCESS_EMULATOR_DEFINES_SVH
`define CP0_ACCESS_EMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CP0AE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cp0ae assertion failed");

// Next-cycle implication, checked outside reset.
`define CP0AE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cp0ae assertion failed");

`endif

FILE: hw/rtl/cp0ae_pkg.sv
// Types and constants for the CP0 access emulator.
package cp0ae_pkg;

	localparam int unsigned NumSlots   = 38;
	localparam int unsigned SlotW      = 6;
	localparam logic [5:0]  SlotStatus = 6'd12;

	localparam logic [5:0] OpcCop0  = 6'h10;
	localparam logic [4:0] RsMf     = 5'h00;
	localparam logic [4:0] RsMt     = 5'h04;
	localparam logic [4:0] RsMfmc0  = 5'h0B;
	localparam logic [5:0] FnTlbr   = 6'h01;
	localparam logic [5:0] FnTlbwi  = 6'h02;
	localparam logic [5:0] FnTlbwr  = 6'h06;
	localparam logic [5:0] FnTlbp   = 6'h08;

	localparam logic [2:0] StDone     = 3'd0;
	localparam logic [2:0] StCopUnus  = 3'd1;
	localparam logic [2:0] StUnmapped = 3'd2;
	localparam logic [2:0] StTlbReq   = 3'd3;
	localparam logic [2:0] StTlbBad   = 3'd4;

	localparam logic [1:0] TlbProbe   = 2'd0;
	localparam logic [1:0] TlbRead    = 2'd1;
	localparam logic [1:0] TlbWriteIx = 2'd2;
	localparam logic [1:0] TlbWriteRn = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_MFC0,
		OP_MTC0,
		OP_DIEI
	} op_t;

	typedef struct packed {
		logic [31:0] inst;
		logic [1:0]  unusable_cop;
		logic [31:0] rt_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  tlb_kind;
		logic        gpr_write;
		logic [4:0]  gpr_index;
		logic [31:0] gpr_data;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [2:0]       status;
		logic [1:0]       tlb_kind;
		logic [SlotW-1:0] slot;
		logic [4:0]       rt;
		logic             ei;
		logic [31:0]      rt_value;
	} dec_t;

endpackage

FILE: hw/rtl/cp0ae_decode.sv
// Instruction decode and (rd, sel) to shadow slot mapping.
module cp0ae_decode (
	input  cp0ae_pkg::cmd_t cmd,
	output cp0ae_pkg::dec_t dec
);

	logic [5:0] opc;
	logic [4:0] rs;
	logic [4:0] rd;
	logic [2:0] sel;
	logic [5:0] funct;
	logic [5:0] slot;
	logic       mapped;
	logic       slot_ok;

	assign opc   = cmd.inst[31:26];
	assign rs    = cmd.inst[25:21];
	assign rd    = cmd.inst[15:11];
	assign sel   = cmd.inst[2:0];
	assign funct = cmd.inst[5:0];

	// Map rd/sel onto a slot; mapped rd with a bad sel yields no slot.
	always_comb begin
		mapped  = 1'b1;
		slot_ok = 1'b1;
		slot    = 6'd0;
		if (rd <= 5'd11) begin
			slot = {1'b0, rd};
		end else begin
			unique case (rd)
				5'd12: begin
					slot_ok = (sel <= 3'd3);
					slot    = 6'd12 + {3'd0, sel};
				end
				5'd13: slot = 6'd16;
				5'd14: slot = 6'd17;
				5'd15: begin
					slot_ok = (sel <= 3'd1);
					slot    = 6'd18 + {3'd0, sel};
				end
				5'd16: begin
					slot_ok = (sel <= 3'd3);
					slot    = 6'd20 + {3'd0, sel};
				end
				5'd17: slot = 6'd24;
				5'd18: slot = 6'd25;
				5'd19: slot = 6'd26;
				5'd23: slot = 6'd27;
				5'd24: slot = 6'd28;
				5'd25: begin
					slot_ok = (sel <= 3'd1);
					slot    = 6'd29 + {3'd0, sel};
				end
				5'd26: slot = 6'd31;
				5'd27: slot = 6'd32;
				5'd28: begin
					slot_ok = (sel <= 3'd1);
					slot    = 6'd33 + {3'd0, sel};
				end
				5'd29: begin
					slot_ok = (sel <= 3'd1);
					slot    = 6'd35 + {3'd0, sel};
				end
				5'd31: slot = 6'd37;
				default: begin
					mapped  = 1'b0;
					slot_ok = 1'b0;
				end
			endcase
		end
		if (!slot_ok) begin
			slot = 6'd0;
		end
	end

	always_comb begin
		dec          = '0;
		dec.op       = cp0ae_pkg::OP_NONE;
		dec.status   = cp0ae_pkg::StDone;
		dec.tlb_kind = cp0ae_pkg::TlbProbe;
		dec.rt       = cmd.inst[20:16];
		dec.ei       = cmd.inst[5];
		dec.rt_value = cmd.rt_value;
		priority if (cmd.unusable_cop != 2'd0) begin
			dec.status = cp0ae_pkg::StCopUnus;
		end else if (opc != cp0ae_pkg::OpcCop0) begin
			dec.status = cp0ae_pkg::StDone;
		end else if (rs[4]) begin
			dec.status = cp0ae_pkg::StTlbReq;
			unique case (funct)
				cp0ae_pkg::FnTlbp:  dec.tlb_kind = cp0ae_pkg::TlbProbe;
				cp0ae_pkg::FnTlbr:  dec.tlb_kind = cp0ae_pkg::TlbRead;
				cp0ae_pkg::FnTlbwi: dec.tlb_kind = cp0ae_pkg::TlbWriteIx;
				cp0ae_pkg::FnTlbwr: dec.tlb_kind = cp0ae_pkg::TlbWriteRn;
				default:            dec.status   = cp0ae_pkg::StTlbBad;
			endcase
		end else if (rs == cp0ae_pkg::RsMf || rs == cp0ae_pkg::RsMt) begin
			if (!mapped) begin
				dec.status = cp0ae_pkg::StUnmapped;
			end else if (slot_ok) begin
				dec.slot = slot;
				dec.op   = (rs == cp0ae_pkg::RsMf) ? cp0ae_pkg::OP_MFC0 : cp0ae_pkg::OP_MTC0;
			end
		end else if (rs == cp0ae_pkg::RsMfmc0) begin
			dec.op   = cp0ae_pkg::OP_DIEI;
			dec.slot = cp0ae_pkg::SlotStatus;
		end
	end

endmodule

FILE: hw/rtl/cp0ae_shadow_file.sv
// Shadow CP0 register file: memory with valid bits plus Status in flops.
module cp0ae_shadow_file (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cp0ae_pkg::dec_t   dec,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [cp0ae_pkg::NumSlots];
	logic [cp0ae_pkg::NumSlots-1:0] valid_q;
	logic [31:0] status_q;
	logic [31:0] mem_rd_s1;
	logic [31:0] status_s1;
	logic        hit_s1;
	logic        use_status_s1;
	logic        is_status;
	logic        mem_wr;

	assign is_status = (dec.slot == cp0ae_pkg::SlotStatus);
	assign mem_wr    = en && (dec.op == cp0ae_pkg::OP_MTC0) && !is_status;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[dec.slot] <= dec.rt_value;
		end
		if (en) begin
			mem_rd_s1 <= mem[dec.slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			status_q      <= '0;
			status_s1     <= '0;
			hit_s1        <= 1'b0;
			use_status_s1 <= 1'b0;
		end else if (en) begin
			if (mem_wr) begin
				valid_q[dec.slot] <= 1'b1;
			end
			// Capture old Status before the update below.
			status_s1     <= status_q;
			hit_s1        <= valid_q[dec.slot];
			use_status_s1 <= is_status;
			unique case (dec.op)
				cp0ae_pkg::OP_MTC0: begin
					if (is_status) begin
						status_q <= dec.rt_value;
					end
				end
				cp0ae_pkg::OP_DIEI: status_q <= {status_q[31:1], dec.ei};
				default: ;
			endcase
		end
	end

	assign rd_data = use_status_s1 ? status_s1 : (hit_s1 ? mem_rd_s1 : 32'd0);

endmodule

FILE: hw/rtl/cp0_access_emulator.sv
// Top level of the CP0 access emulator: decode, shadow file, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  command  | start in, busy out   | cmd (inst, unusable_cop, rt_value)
//  result   | done out (strobe)    | rsp (status, tlb_kind, gpr_write/index/data)
//
// One item per cycle sustained; busy stays low. Each item yields exactly one
// result, through the registered shadow file read and then the result register.
// Reset clears the shadow file at once through per-entry valid bits.
// The receiver cannot stall; results go out in item order, one per strobe.
`include "cp0_access_emulator_defines.svh"

module cp0_access_emulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cp0ae_pkg::cmd_t   cmd,
	output logic              done,
	output cp0ae_pkg::rsp_t   rsp
);

	cp0ae_pkg::dec_t dec;
	logic            accept;
	logic [31:0]     rd_data;

	// Stage one: decoded item alongside the registered file read.
	logic            vld_s1;
	cp0ae_pkg::op_t  op_s1;
	logic [2:0]      status_s1;
	logic [1:0]      tlb_kind_s1;
	logic [4:0]      rt_s1;

	logic            done_q;
	cp0ae_pkg::rsp_t rsp_q;
	cp0ae_pkg::rsp_t rsp_d;
	logic            wr_d;

	// Never blocks: every item completes in a fixed pipeline.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	cp0ae_decode u_decode (
		.cmd (cmd),
		.dec (dec)
	);

	// Apply stores and read the shadow file on the accept edge.
	cp0ae_shadow_file u_shadow (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.dec     (dec),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			op_s1  <= cp0ae_pkg::OP_NONE;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				op_s1 <= dec.op;
			end
		end
	end

	// Payload of stage one: hold between items.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= dec.status;
			tlb_kind_s1 <= dec.tlb_kind;
			rt_s1       <= dec.rt;
		end
	end

	// MFC0 always writes rt; DI/EI writes only a nonzero rt.
	assign wr_d = (op_s1 == cp0ae_pkg::OP_MFC0) ||
		((op_s1 == cp0ae_pkg::OP_DIEI) && (rt_s1 != 5'd0));

	always_comb begin
		rsp_d.status    = status_s1;
		rsp_d.tlb_kind  = tlb_kind_s1;
		rsp_d.gpr_write = wr_d;
		rsp_d.gpr_index = wr_d ? rt_s1 : 5'd0;
		rsp_d.gpr_data  = wr_d ? rd_data : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`CP0AE_ASSERT_NEXT(a_s1_follows_accept, clk, arst_n, accept, vld_s1)
	`CP0AE_ASSERT_NEXT(a_done_follows_s1, clk, arst_n, vld_s1, done)
	`CP0AE_ASSERT_IMPL(a_write_only_on_done, clk, arst_n, done && rsp.gpr_write, rsp.status == cp0ae_pkg::StDone)
	`CP0AE_ASSERT_IMPL(a_no_write_zeroed, clk, arst_n, done && !rsp.gpr_write, (rsp.gpr_index == 5'd0) && (rsp.gpr_data == 32'd0))
	`CP0AE_ASSERT_IMPL(a_kind_only_tlb, clk, arst_n, done && (rsp.status != cp0ae_pkg::StTlbReq), rsp.tlb_kind == cp0ae_pkg::TlbProbe)

endmodule

FILE: test/tb.sv
// Testbench for the CP0 access emulator: bursty driver, shadow-file predictor, checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Slot lookup outcomes that do not name a shadow entry.
	localparam int SlotBadRd  = -1;  // rd has no mapping at all
	localparam int SlotNoSel  = -2;  // rd is mapped, sel is not

	localparam int RandomItems = 450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cp0ae_pkg::cmd_t cmd = '0;
	logic done;
	cp0ae_pkg::rsp_t rsp;

	cp0_access_emulator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// Items waiting to be driven, and results owed by the block in item order.
	cp0ae_pkg::cmd_t cmd_backlog [$];
	cp0ae_pkg::rsp_t rsp_due [$];

	// Our own copy of the guest CP0 shadow file, all zero after reset.
	logic [31:0] guest_cp0 [cp0ae_pkg::NumSlots];

	int errors = 0;
	int items_taken = 0;
	int results_checked = 0;
	int gpr_writes_seen = 0;
	int status_seen [5] = '{default: 0};

	// Sender burst shaping.
	int burst_left = 1;
	int gap_left = 0;

	cp0ae_pkg::rsp_t owed;

	initial begin
		forever #4 clk = ~clk;
	end

	// Map (rd, sel) onto a shadow slot. Registers below 12 and those without
	// a select field ignore sel entirely.
	function automatic int slot_for(logic [4:0] rd, logic [2:0] sel);
		if (rd <= 5'd11)
			return int'(rd);
		case (rd)
			5'd12: return (sel <= 3'd3) ? 12 + int'(sel) : SlotNoSel;
			5'd13: return 16;
			5'd14: return 17;
			5'd15: return (sel <= 3'd1) ? 18 + int'(sel) : SlotNoSel;
			5'd16: return (sel <= 3'd3) ? 20 + int'(sel) : SlotNoSel;
			5'd17: return 24;
			5'd18: return 25;
			5'd19: return 26;
			5'd23: return 27;
			5'd24: return 28;
			5'd25: return (sel <= 3'd1) ? 29 + int'(sel) : SlotNoSel;
			5'd26: return 31;
			5'd27: return 32;
			5'd28: return (sel <= 3'd1) ? 33 + int'(sel) : SlotNoSel;
			5'd29: return (sel <= 3'd1) ? 35 + int'(sel) : SlotNoSel;
			5'd31: return 37;
			default: return SlotBadRd;
		endcase
	endfunction

	// Emulate one trapped instruction against guest_cp0 and return the result
	// the block owes for it. Updates the shadow copy as a side effect.
	function automatic cp0ae_pkg::rsp_t emulate_cp0(cp0ae_pkg::cmd_t c);
		cp0ae_pkg::rsp_t r;
		logic [4:0] rs;
		logic [4:0] rt;
		int slot;
		r = '0;
		r.status = cp0ae_pkg::StDone;
		r.tlb_kind = cp0ae_pkg::TlbProbe;
		rs = c.inst[25:21];
		rt = c.inst[20:16];
		if (c.unusable_cop != 2'd0) begin
			// Trap came from another coprocessor: report only.
			r.status = cp0ae_pkg::StCopUnus;
		end else if (c.inst[31:26] == cp0ae_pkg::OpcCop0) begin
			if (rs[4]) begin
				// CO set: TLB ops are forwarded as a request, anything else is unknown.
				r.status = cp0ae_pkg::StTlbReq;
				case (c.inst[5:0])
					cp0ae_pkg::FnTlbp:  r.tlb_kind = cp0ae_pkg::TlbProbe;
					cp0ae_pkg::FnTlbr:  r.tlb_kind = cp0ae_pkg::TlbRead;
					cp0ae_pkg::FnTlbwi: r.tlb_kind = cp0ae_pkg::TlbWriteIx;
					cp0ae_pkg::FnTlbwr: r.tlb_kind = cp0ae_pkg::TlbWriteRn;
					default: begin
						r.status = cp0ae_pkg::StTlbBad;
						r.tlb_kind = cp0ae_pkg::TlbProbe;
					end
				endcase
			end else if (rs == cp0ae_pkg::RsMf || rs == cp0ae_pkg::RsMt) begin
				slot = slot_for(c.inst[15:11], c.inst[2:0]);
				if (slot == SlotBadRd) begin
					r.status = cp0ae_pkg::StUnmapped;
				end else if (slot >= 0) begin
					if (rs == cp0ae_pkg::RsMf) begin
						// rt of zero still produces the write; GPR 0 discards it.
						r.gpr_write = 1'b1;
						r.gpr_index = rt;
						r.gpr_data = guest_cp0[slot];
					end else begin
						guest_cp0[slot] = c.rt_value;
					end
				end
			end else if (rs == cp0ae_pkg::RsMfmc0) begin
				// DI/EI: hand back old Status unless rt is zero, then set IE from instruction bit 5.
				if (rt != 5'd0) begin
					r.gpr_write = 1'b1;
					r.gpr_index = rt;
					r.gpr_data = guest_cp0[cp0ae_pkg::SlotStatus];
				end
				guest_cp0[cp0ae_pkg::SlotStatus][0] = c.inst[5];
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] cop0_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [10:0] tail);
		return {cp0ae_pkg::OpcCop0, rs, rt, rd, tail};
	endfunction

	task automatic queue_cmd(logic [31:0] inst, logic [1:0] cop, logic [31:0] rtv);
		cp0ae_pkg::cmd_t c;
		c.inst = inst;
		c.unusable_cop = cop;
		c.rt_value = rtv;
		cmd_backlog.push_back(c);
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// Driver: retire the item taken at this edge into the predictor, then load
	// the next one unless a gap is running. start gets one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				rsp_due.push_back(emulate_cp0(cmd));
				items_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					cmd <= cmd_backlog.pop_front();
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// End of burst: pick the next gap (often none) and burst length.
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobe must match the oldest owed result, field by field.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (rsp_due.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing expected: expected none, actual %p",
					$time, rsp);
			end else begin
				owed = rsp_due.pop_front();
				check_field("status", 32'(owed.status), 32'(rsp.status));
				check_field("tlb_kind", 32'(owed.tlb_kind), 32'(rsp.tlb_kind));
				check_field("gpr_write", 32'(owed.gpr_write), 32'(rsp.gpr_write));
				check_field("gpr_index", 32'(owed.gpr_index), 32'(rsp.gpr_index));
				check_field("gpr_data", owed.gpr_data, rsp.gpr_data);
				results_checked++;
				if (owed.gpr_write)
					gpr_writes_seen++;
				if (owed.status <= cp0ae_pkg::StTlbBad)
					status_seen[owed.status]++;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int pick;
		logic [4:0] rd;
		logic [2:0] sel;
		logic [4:0] rs;
		logic [5:0] funct;
		logic [1:0] cop;

		foreach (guest_cp0[i])
			guest_cp0[i] = '0;

		// Directed: Status round trip, DI/EI with and without rt.
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd3, 5'd12, 11'h000), 2'd0, 32'hFFFF_FFFF);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd31, 5'd12, 11'h000), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMfmc0, 5'd5, 5'd12, 11'h000), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMfmc0, 5'd0, 5'd12, 11'h020), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMfmc0, 5'd0, 5'd12, 11'h000), 2'd0, 32'hFFFF_FFFF);
		queue_cmd(cop0_word(cp0ae_pkg::RsMfmc0, 5'd7, 5'd12, 11'h7FF), 2'd0, 32'h0);
		// MFC0 into GPR 0 still writes.
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd0, 5'd12, 11'h000), 2'd0, 32'h0);
		// Register without a select: sel is ignored on both write and read.
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd9, 11'h005), 2'd0, 32'hA5A5_A5A5);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd2, 5'd9, 11'h000), 2'd0, 32'h0);
		// Mapped rd, unmapped sel: nothing stored, nothing returned.
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd12, 11'h004), 2'd0, 32'h1);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd1, 5'd12, 11'h004), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd4, 5'd15, 11'h007), 2'd0, 32'h0);
		// rd with no mapping.
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd1, 5'd20, 11'h000), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd1, 5'd21, 11'h000), 2'd0, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd22, 11'h000), 2'd0, 32'h1234_5678);
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd30, 11'h7FF), 2'd0, 32'hFFFF_FFFF);
		// Another coprocessor trapped: report only, no store.
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd0, 11'h000), 2'd1, 32'hDEAD_BEEF);
		queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'd1, 5'd0, 11'h000), 2'd2, 32'h0);
		queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'd1, 5'd31, 11'h000), 2'd3, 32'hFFFF_FFFF);
		// Not COP0, and COP0 with an rs we do not emulate.
		queue_cmd(32'h0000_0000, 2'd0, 32'h0);
		queue_cmd(32'hFFFF_FFFF, 2'd0, 32'hFFFF_FFFF);
		queue_cmd(cop0_word(5'h01, 5'd1, 5'd12, 11'h000), 2'd0, 32'h5555_5555);
		// TLB ops and an unknown CO function.
		queue_cmd(cop0_word(5'h10, 5'd0, 5'd0, {5'h00, cp0ae_pkg::FnTlbp}), 2'd0, 32'h0);
		queue_cmd(cop0_word(5'h10, 5'd0, 5'd0, {5'h00, cp0ae_pkg::FnTlbr}), 2'd0, 32'h0);
		queue_cmd(cop0_word(5'h1F, 5'd31, 5'd31, {5'h1F, cp0ae_pkg::FnTlbwi}), 2'd0, 32'h0);
		queue_cmd(cop0_word(5'h10, 5'd0, 5'd0, {5'h00, cp0ae_pkg::FnTlbwr}), 2'd0, 32'h0);
		queue_cmd(cop0_word(5'h10, 5'd0, 5'd0, 11'h018), 2'd0, 32'h0);

		// Random: mostly well-formed MTC0/MFC0/DI/EI/TLB with random content,
		// the rest other coprocessors and raw noise.
		for (int n = 0; n < RandomItems; n++) begin
			pick = $urandom_range(0, 99);
			rd = 5'($urandom_range(0, 31));
			sel = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3))
				: 3'($urandom_range(0, 7));
			if (pick < 35) begin
				queue_cmd(cop0_word(cp0ae_pkg::RsMt, 5'($urandom), rd, {8'($urandom), sel}),
					2'd0, $urandom);
			end else if (pick < 65) begin
				queue_cmd(cop0_word(cp0ae_pkg::RsMf, 5'($urandom), rd, {8'($urandom), sel}),
					2'd0, $urandom);
			end else if (pick < 75) begin
				queue_cmd(cop0_word(cp0ae_pkg::RsMfmc0, 5'($urandom), 5'($urandom),
					11'($urandom)), 2'd0, $urandom);
			end else if (pick < 85) begin
				rs = {1'b1, 4'($urandom)};
				case ($urandom_range(0, 4))
					0: funct = cp0ae_pkg::FnTlbp;
					1: funct = cp0ae_pkg::FnTlbr;
					2: funct = cp0ae_pkg::FnTlbwi;
					3: funct = cp0ae_pkg::FnTlbwr;
					default: funct = 6'($urandom);
				endcase
				queue_cmd(cop0_word(rs, 5'($urandom), 5'($urandom), {5'($urandom), funct}),
					2'd0, $urandom);
			end else if (pick < 90) begin
				cop = 2'($urandom_range(1, 3));
				queue_cmd(cop0_word(5'($urandom), 5'($urandom), rd, {8'($urandom), sel}), cop,
					$urandom);
			end else begin
				cop = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd0;
				queue_cmd($urandom, cop, $urandom);
			end
		end

		// Hold reset, then release it once.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all items taken, all owed results back, then a short tail
		// to catch any stray strobe.
		wait (cmd_backlog.size() == 0 && !start);
		wait (rsp_due.size() == 0);
		repeat (10) @(posedge clk);

		$display("Ran %0d items, checked %0d results (%0d GPR writes).",
			items_taken, results_checked, gpr_writes_seen);
		$display("Status mix: done %0d, cop unusable %0d, unmapped %0d, tlb %0d, bad tlb %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legitimate run.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
